// File: hdl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define AST_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, sampled on clk and disabled during rst.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

// File: hdl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

  // Number of low bits of the input that form the integer.
  localparam int VALUE_WIDTH = 32;
  localparam int IN_WIDTH = 32;

  // Decimal digits needed for the largest magnitude, 2**(VALUE_WIDTH-1).
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;

  localparam int DIGIT_W = 4;
  localparam int CHAR_W = 6;
  localparam int BIT_CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(NUM_DIGITS + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_ZERO = 6'd48;
  localparam logic [CHAR_W-1:0] CH_NINE = 6'd57;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Control that the sequencer hands to every digit cell.
  typedef struct packed {
    logic clear;   // zero the digit
    logic dabble;  // correct and shift in one binary bit
    logic move;    // take the digit of the lower neighbor
  } cell_ctrl_t;

endpackage

// File: hdl/itoa_cell.sv
`timescale 1ns / 1ps

module itoa_cell (
  input  logic               clk,
  input  itoa_pkg::cell_ctrl_t ctrl,
  input  logic               bit_in,
  input  itoa_pkg::digit_t   digit_in,
  output logic               bit_out,
  output itoa_pkg::digit_t   digit
);
  import itoa_pkg::*;

  digit_t corrected;

  // Add three when the digit is five or more, so the shift doubles it in BCD.
  always_comb begin
    if (digit >= digit_t'(5)) begin
      corrected = digit + digit_t'(3);
    end else begin
      corrected = digit;
    end
  end

  assign bit_out = corrected[DIGIT_W-1];

  // One BCD digit of the chain.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.dabble) begin
      digit <= {corrected[DIGIT_W-2:0], bit_in};
    end else if (ctrl.move) begin
      digit <= digit_in;
    end
  end

endmodule

// File: hdl/signed_integer_to_decimal_text.sv
`timescale 1ns / 1ps

// Signed integer to decimal ASCII text.
// Input channel: value with in_valid / in_ready. A transfer takes one signed
// integer; in_ready is high only while the converter is free.
// Output channel: char_code and is_last with out_valid / out_ready. Each
// integer gives a run of 1 to 11 characters, most significant first, with a
// leading minus sign for a negative value; is_last marks the final one.
// Conversion: the magnitude is fed bit by bit into a chain of BCD digit cells
// (double dabble). Leading zero digits are then shifted out of the top cell at
// one per cycle, and the characters follow, one per cycle while the receiver
// keeps out_ready high. A new integer is taken only after the last digit of
// the previous one has been moved into the output register.
// The last character sits in an output register, so a new integer may be
// taken while it waits. When the receiver stalls, the output register holds
// its character and the digit chain holds its digits until the transfer.
// Reset (rst, synchronous) empties the output register and returns the
// sequencer to idle; the digit cells need no reset.
module signed_integer_to_decimal_text (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic signed [itoa_pkg::IN_WIDTH-1:0] value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [itoa_pkg::CHAR_W-1:0]     char_code,
  output logic                            is_last
);
  import itoa_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   sign_pending;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [REM_W-1:0]       rem;
  logic                   in_xfer;
  logic                   slot_free;
  logic                   emit_digit;
  logic                   emit_sign;
  cell_ctrl_t             ctrl;
  digit_t                 digits [NUM_DIGITS];
  logic                   bits [NUM_DIGITS];
  digit_t                 top_digit;

  assign raw = VALUE_WIDTH'(unsigned'(value));
  assign in_ready = (state == ST_IDLE);
  assign in_xfer = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign top_digit = digits[NUM_DIGITS-1];
  assign emit_sign = (state == ST_EMIT) && slot_free && sign_pending;
  assign emit_digit = (state == ST_EMIT) && slot_free && !sign_pending;

  // Cell chain control.
  always_comb begin
    ctrl.clear = in_xfer;
    ctrl.dabble = (state == ST_CONV);
    ctrl.move = emit_digit ||
                ((state == ST_SKIP) && (top_digit == '0) && (rem != REM_W'(1)));
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (bit_cnt == '0) begin
          state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if ((top_digit != '0) || (rem == REM_W'(1))) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_digit && (rem == REM_W'(1))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Magnitude shift register, bit counter, digit count and sign flag.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mag <= raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
      sign_pending <= raw[VALUE_WIDTH-1];
      bit_cnt <= BIT_CNT_W'(VALUE_WIDTH - 1);
      rem <= REM_W'(NUM_DIGITS);
    end else begin
      if (state == ST_CONV) begin
        mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
        bit_cnt <= bit_cnt - BIT_CNT_W'(1);
      end
      if (ctrl.move) begin
        rem <= rem - REM_W'(1);
      end
      if (emit_sign) begin
        sign_pending <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_sign || emit_digit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_sign) begin
      char_code <= CH_MINUS;
      is_last <= 1'b0;
    end else if (emit_digit) begin
      char_code <= CH_ZERO + CHAR_W'(top_digit);
      is_last <= (rem == REM_W'(1));
    end
  end

  // Row of BCD digit cells; cell 0 is the least significant digit.
  assign bits[0] = mag[VALUE_WIDTH-1];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_low
      itoa_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bits[0]),
        .digit_in ('0),
        .bit_out  (bits[1]),
        .digit    (digits[0])
      );
    end else if (i == NUM_DIGITS - 1) begin : g_top
      itoa_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bits[i]),
        .digit_in (digits[i-1]),
        .bit_out  (),
        .digit    (digits[i])
      );
    end else begin : g_mid
      itoa_cell u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .bit_in   (bits[i]),
        .digit_in (digits[i-1]),
        .bit_out  (bits[i+1]),
        .digit    (digits[i])
      );
    end
  end

endmodule

// File: hdl/itoa_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module itoa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [itoa_pkg::IN_WIDTH-1:0]   value,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [itoa_pkg::CHAR_W-1:0]     char_code,
  input logic                            is_last
);
  import itoa_pkg::*;

  logic in_xfer;
  logic [IN_WIDTH-1:0] value_seen;

  assign in_xfer = in_valid && in_ready;
  assign value_seen = value;

  // A stalled character holds until its transfer.
  `AST_NEXT(a_out_hold, out_valid && !out_ready,
            out_valid && $stable(char_code) && $stable(is_last))

  // Only a minus sign or a digit is ever shown.
  `AST_IMPLIES(a_char_range, out_valid,
               char_code == CH_MINUS || (char_code >= CH_ZERO && char_code <= CH_NINE))

  // A minus sign never ends a run.
  `AST_IMPLIES(a_minus_not_last, out_valid && char_code == CH_MINUS, !is_last)

  // After an integer is taken the converter is busy in the next cycle.
  `AST_NEXT(a_busy_after_take, in_xfer && (value_seen == value), !in_ready)

endmodule

bind signed_integer_to_decimal_text itoa_checker u_itoa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .value     (value),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .char_code (char_code),
  .is_last   (is_last)
);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import itoa_pkg::*;

  localparam int RANDOM_ITEMS = 280;
  localparam int HOLD_AT_ITEM = 120;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_CAP = 40;
  localparam int NUM_ROWS = 22;

  // One character of the decimal text as it should leave the block.
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  // A directed row: the integer and, where it is obvious, its text.
  typedef struct {
    logic [IN_WIDTH-1:0] num;
    string               text;
  } stim_row_t;

  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [IN_WIDTH-1:0] value = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CHAR_W-1:0]   char_code;
  logic                is_last;

  text_char_t pending_chars[$];
  text_char_t want_char;
  string      typed_text = "";
  int         burst_left = 0;
  bit         hold_req = 1'b0;
  int         error_count = 0;
  int         cycle_count = 0;
  int         values_taken = 0;
  int         negatives_taken = 0;
  int         chars_seen = 0;
  int         run_len = 0;
  int         longest_run = 0;
  int         stall_cycles = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{32'd0, "0"},
    '{32'd1, "1"},
    '{-32'sd1, "-1"},
    '{32'd9, "9"},
    '{32'd10, "10"},
    '{-32'sd10, "-10"},
    '{32'd100, "100"},
    '{-32'sd100, "-100"},
    '{32'h7FFF_FFFF, "2147483647"},
    '{32'h8000_0000, "-2147483648"},
    '{32'h8000_0001, "-2147483647"},
    '{32'd999999999, "999999999"},
    '{-32'sd999999999, "-999999999"},
    '{32'd1000000000, "1000000000"},
    '{32'd1999999999, "1999999999"},
    '{32'd12345, "12345"},
    '{32'h5555_5555, ""},
    '{32'hAAAA_AAAA, ""},
    '{32'hFFFF_0000, ""},
    '{32'h0000_FFFF, ""},
    '{32'h7FFF_0000, ""},
    '{32'hDEAD_BEEF, ""}
  };

  signed_integer_to_decimal_text u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .is_last   (is_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Work out the text of one integer: sign, then digits with no leading zeros.
  function automatic void predict_text(input logic [IN_WIDTH-1:0] num);
    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic                   neg;
    logic [3:0]             digits[$];
    raw = num[VALUE_WIDTH-1:0];
    neg = raw[VALUE_WIDTH-1];
    // The magnitude is unsigned, so the most negative value stays exact.
    mag = neg ? (~raw + 1'b1) : raw;
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      pending_chars.push_back(text_char_t'{CH_MINUS, 1'b0});
    end
    foreach (digits[i]) begin
      pending_chars.push_back(text_char_t'{CH_ZERO + CHAR_W'(digits[i]),
                                           i == digits.size() - 1});
    end
  endfunction

  // Queue a text that was typed into the directed table.
  function automatic void queue_typed_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      pending_chars.push_back(text_char_t'{CHAR_W'(txt[i]), i == txt.len() - 1});
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [CHAR_W-1:0] got,
                                 input logic [CHAR_W-1:0] want);
    if (error_count < PRINT_CAP) begin
      $display("Mismatch at cycle %0d: %s, got %0d, expected %0d",
               cycle_count, what, got, want);
    end
    error_count++;
  endtask

  // Draw an integer: full-range noise, numbers of a random digit count,
  // values next to powers of ten, and small values.
  function automatic logic [IN_WIDTH-1:0] random_value();
    longint unsigned span;
    longint unsigned mag;
    int              ndig;
    bit              neg;
    neg = $urandom_range(0, 1);
    mag = 0;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        ndig = $urandom_range(1, 10);
        span = 1;
        repeat (ndig) span = span * 10;
        mag = longint'($urandom) % span;
      end
      2: begin
        ndig = $urandom_range(0, 9);
        span = 1;
        repeat (ndig) span = span * 10;
        mag = span + $urandom_range(0, 2) - 1;
      end
      default: mag = $urandom_range(0, 999);
    endcase
    return neg ? IN_WIDTH'(-mag) : IN_WIDTH'(mag);
  endfunction

  // Offer one integer in bursts with random gaps, and wait for its transfer.
  task automatic offer_value(input logic [IN_WIDTH-1:0] num, input string txt);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      value <= $urandom;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 10);
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(20, 40);
      end
    end
    in_valid <= 1'b1;
    value <= num;
    typed_text = txt;
    burst_left--;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Scoreboard: queue the text of every input transfer, then check each
  // output transfer against the oldest pending character.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (typed_text != "") begin
          queue_typed_text(typed_text);
        end else begin
          predict_text(value);
        end
        values_taken++;
        if (value[VALUE_WIDTH-1]) begin
          negatives_taken++;
        end
      end
      if (in_valid && !in_ready && !out_ready) begin
        stall_cycles++;
      end
      if (out_valid && out_ready) begin
        chars_seen++;
        run_len++;
        if (pending_chars.size() == 0) begin
          report_mismatch("character with nothing pending", char_code, '0);
        end else begin
          want_char = pending_chars.pop_front();
          if (char_code !== want_char.code) begin
            report_mismatch("char_code", char_code, want_char.code);
          end
          if (is_last !== want_char.last) begin
            report_mismatch("is_last", CHAR_W'(is_last), CHAR_W'(want_char.last));
          end
        end
        if (is_last) begin
          if (run_len > longest_run) begin
            longest_run = run_len;
          end
          run_len = 0;
        end
      end
    end
  end

  // Receiver: switches among stall patterns, with one long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       phase;
    mode = RX_STEADY;
    mode_left = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        hold_req = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        phase++;
        case (mode)
          RX_STEADY: out_ready <= 1'b1;
          RX_COIN: out_ready <= ($urandom_range(0, 1) == 1);
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ((phase % 7) < 3);
        endcase
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d characters pending",
               pending_chars.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random integers, then drain.
  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      offer_value(directed_rows[i].num, directed_rows[i].text);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == HOLD_AT_ITEM) begin
        hold_req = 1'b1;
      end
      offer_value(random_value(), "");
    end
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d integers (%0d negative) into %0d characters.",
             values_taken, negatives_taken, chars_seen);
    $display("Longest text was %0d characters; input stalled %0d cycles under hold-off.",
             longest_run, stall_cycles);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
